FILE: design/assert_macros.svh
// Assertion macros shared by the boundary pixel detector RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BPD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A property whose consequent must hold in the cycle after its antecedent.
`define BPD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bpd_pkg.sv
// Package of the alpha boundary pixel detector: field widths, codes and shared types.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpd_pkg;

   localparam int KIND_W    = 1;
   localparam int PIX_W     = 32;
   localparam int CFG_W     = 11;
   localparam int EDGE_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int ALPHA_LSB = 24;
   localparam int ALPHA_W   = 8;

   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic [KIND_W-1:0] KIND_PIXEL = 1'b0;
   localparam logic [KIND_W-1:0] KIND_PAD   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Side length that both size registers take at reset, before clamping.
   localparam int SIDE_RESET = 1024;

   // Opaque flags of one row: the newest column and the column before it.
   typedef struct packed {
      logic older;
      logic prev;
   } bpd_cell_state_type;

   // Commands from the controller to every cell of the ring.
   typedef struct packed {
      logic shift;
      logic poke;
      logic tail_older;
      logic tail_prev;
   } bpd_ring_ctrl_type;

endpackage

`default_nettype wire

FILE: design/bpd_cell.sv
// One cell of the row ring: holds the two opaque flags of one image row.
// Depends on bpd_pkg for the cell state and ring command types.
`default_nettype none

module bpd_cell import bpd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  bpd_ring_ctrl_type  ctrl,
   input  logic               in_ring,
   input  logic               is_tail,
   input  logic               is_poke,
   input  bpd_cell_state_type next_state,
   output bpd_cell_state_type state
);

   bpd_cell_state_type state_ff;
   bpd_cell_state_type state_in;

   always_comb begin
      state_in = state_ff;
      if (ctrl.shift && in_ring) begin
         if (is_tail) begin
            state_in.older = ctrl.tail_older;
            state_in.prev  = ctrl.tail_prev;
         end else begin
            state_in = next_state;
         end
      end else if (ctrl.poke && is_poke) begin
         state_in.older = state_ff.prev;
         state_in.prev  = ctrl.tail_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

`default_nettype wire

FILE: design/bpd_ring.sv
// Row ring of the boundary pixel detector: a chain of bpd_cell instances.
// Depends on bpd_pkg and bpd_cell.
`default_nettype none

module bpd_ring import bpd_pkg::*; #(
   parameter int MAX_SIDE = 1024,
   parameter int LEN_W    = $clog2(MAX_SIDE + 1),
   parameter int ROW_W    = $clog2(MAX_SIDE)
) (
   input  logic               clock,
   input  logic               reset,
   input  bpd_ring_ctrl_type  ctrl,
   input  logic [LEN_W-1:0]   ring_len,
   input  logic [ROW_W-1:0]   poke_row,
   output bpd_cell_state_type head,
   output logic               next_prev
);

   bpd_cell_state_type cells [MAX_SIDE];

   // Cells below ring_len rotate towards cell 0 on every shift and the tail
   // cell takes the row that leaves the head; cells beyond stay in place.
   for (genvar i = 0; i < MAX_SIDE; i++) begin : g_cell
      localparam logic [LEN_W-1:0] IDX    = LEN_W'(i);
      localparam logic [LEN_W-1:0] IDX_P1 = LEN_W'(i + 1);
      localparam logic [ROW_W-1:0] ROW    = ROW_W'(i);

      bpd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .in_ring    (IDX < ring_len),
         .is_tail    (IDX_P1 == ring_len),
         .is_poke    (ROW == poke_row),
         .next_state (cells[(i + 1) % MAX_SIDE]),
         .state      (cells[i])
      );
   end

   assign head      = cells[0];
   assign next_prev = cells[1].prev;

endmodule

`default_nettype wire

FILE: design/alpha_boundary_pixel_detect_top.sv
// Alpha boundary pixel detector: one pixel transaction per clock unless stalled.
// Pixels arrive column by column, rows inner. A pixel whose alpha is not 255 is reported
// by its column and row when its left, right, upper or lower neighbour inside the image
// has alpha 255; decisions lag one column, and after each frame the host sends
// image_height padding transactions to decide the last column and restart the counters.
// The opaque flags of the two newest columns live in a ring of MAX_SIDE cells that
// rotates by one row per transaction, so the current row always sits in the first cell
// and the row below it in the second. In steady operation the block takes one request
// transaction in every cycle; the only limit is the result register, which is refilled
// in the same cycle in which its transaction is taken. After a change of image_height
// the ring is first rotated back into row order and then forward to the current row,
// which holds off requests until done; it starts as soon as the height changes. Reset
// clears all flags at once, with no clearing pass. The user must write the size registers
// through the csr_ port only while the block is idle; the block does not enforce it. They
// are clamped to the range 1 to MAX_SIDE; results report coordinates modulo 1024.
// Depends on bpd_pkg, bpd_ring, bpd_cell and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module alpha_boundary_pixel_detect_top import bpd_pkg::*; #(
   parameter int MAX_SIDE = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [PIX_W-1:0]     req_pixel_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [EDGE_W-1:0]    rsp_edge_x,
   output logic [EDGE_W-1:0]    rsp_edge_y,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int ROW_W  = $clog2(MAX_SIDE);
   localparam int CMP_W  = (CFG_W > SIDE_W) ? CFG_W : SIDE_W;
   localparam logic [SIDE_W-1:0] SIDE_RST =
      SIDE_W'((SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET);

   // Clamp a written size into the range the ring can hold.
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] vw;
      logic [SIDE_W-1:0] res;
      vw = CMP_W'(v);
      if (vw == '0) begin
         res = SIDE_W'(1);
      end else if (vw > CMP_W'(MAX_SIDE)) begin
         res = SIDE_W'(MAX_SIDE);
      end else begin
         res = SIDE_W'(vw);
      end
      return res;
   endfunction

   // Configuration, counters and ring bookkeeping.
   logic [SIDE_W-1:0] width_ff, width_in;
   logic [SIDE_W-1:0] height_ff, height_in;
   logic [SIDE_W-1:0] len_ff, len_in;
   logic [ROW_W-1:0]  rot_ff, rot_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic              last_older_ff, last_older_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [EDGE_W-1:0] rsp_x_ff, rsp_x_in;
   logic [EDGE_W-1:0] rsp_y_ff, rsp_y_in;

   bpd_ring_ctrl_type  ring_ctrl;
   bpd_cell_state_type head;
   logic               next_prev;

   logic [SIDE_W-1:0] row_ext, rot_ext, row_p1, rot_p1, col_m1;
   logic row_in_ring, aligned, out_free, req_fire, is_pad, cur, excess, step;
   logic row_wrap, rot_wrap, len_switch, decide, left, right, up, down, hit;

   bpd_ring #(
      .MAX_SIDE (MAX_SIDE),
      .LEN_W    (SIDE_W),
      .ROW_W    (ROW_W)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ring_ctrl),
      .ring_len  (len_ff),
      .poke_row  (row_ff),
      .head      (head),
      .next_prev (next_prev)
   );

   always_comb begin
      row_ext     = SIDE_W'(row_ff);
      rot_ext     = SIDE_W'(rot_ff);
      row_p1      = row_ext + SIDE_W'(1);
      rot_p1      = rot_ext + SIDE_W'(1);
      col_m1      = col_ff - SIDE_W'(1);
      row_in_ring = row_ext < len_ff;

      // The ring is usable once it has the current height and the current
      // row sits in the first cell; a row beyond the height needs row order.
      aligned  = (len_ff == height_ff) && (row_in_ring ? (rot_ff == row_ff) : (rot_ff == '0));
      out_free = !rsp_valid_ff || !rsp_stall;
      req_fire = req_valid && aligned && out_free;

      is_pad = (req_kind == KIND_PAD);
      cur    = (req_kind == KIND_PIXEL) &&
               (req_pixel_word[ALPHA_LSB +: ALPHA_W] == ALPHA_OPAQUE);
      // Pixels beyond the configured width are taken and dropped.
      excess = !is_pad && (col_ff >= width_ff);
      step   = req_fire && !excess;

      row_wrap   = row_p1 >= height_ff;
      rot_wrap   = rot_p1 >= len_ff;
      len_switch = !aligned && (len_ff != height_ff) && (rot_ff == '0);

      // The arriving transaction decides the pixel one column to the left.
      decide = (col_ff != '0) && (col_ff <= width_ff) && (row_ext < height_ff);
      left   = (col_ff > SIDE_W'(1)) && head.older;
      right  = !is_pad && (col_ff < width_ff) && cur;
      up     = (row_ff != '0) && last_older_ff;
      down   = (row_p1 < height_ff) && next_prev;
      hit    = step && decide && !head.prev && (left || right || up || down);

      ring_ctrl = '0;
      if (step) begin
         if (row_in_ring) begin
            ring_ctrl.shift      = 1'b1;
            ring_ctrl.tail_older = head.prev;
            ring_ctrl.tail_prev  = cur;
         end else begin
            // A row outside the ring after the height shrank: update in place.
            ring_ctrl.poke      = 1'b1;
            ring_ctrl.tail_prev = cur;
         end
      end else if (!aligned && !len_switch) begin
         // Realignment: a plain rotation that leaves every flag unchanged.
         ring_ctrl.shift      = 1'b1;
         ring_ctrl.tail_older = head.older;
         ring_ctrl.tail_prev  = head.prev;
      end
   end

   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      len_in        = len_ff;
      rot_in        = rot_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      last_older_in = last_older_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = clamp_side(csr_wdata);
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = clamp_side(csr_wdata);
            end
            default: begin
            end
         endcase
      end

      if (len_switch) begin
         len_in = height_ff;
      end

      if (ring_ctrl.shift) begin
         rot_in        = rot_wrap ? '0 : ROW_W'(rot_p1);
         last_older_in = ring_ctrl.tail_older;
      end

      if (step) begin
         if (row_wrap) begin
            row_in = '0;
            col_in = is_pad ? '0 : (col_ff + SIDE_W'(1));
         end else begin
            row_in = ROW_W'(row_p1);
         end
      end

      if (req_fire) begin
         rsp_valid_in = hit;
         rsp_x_in     = EDGE_W'(col_m1);
         rsp_y_in     = EDGE_W'(row_ff);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= SIDE_RST;
         height_ff     <= SIDE_RST;
         len_ff        <= SIDE_RST;
         rot_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         last_older_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         len_ff        <= len_in;
         rot_ff        <= rot_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         last_older_ff <= last_older_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign req_stall  = !(aligned && out_free);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_edge_x = rsp_x_ff;
   assign rsp_edge_y = rsp_y_ff;

   `BPD_ASSERT(a_rot_in_ring, clock, reset, rot_ext < len_ff,
      "ring rotation beyond ring length")
   `BPD_ASSERT(a_fire_on_head, clock, reset, !(req_fire && row_in_ring) || (rot_ff == row_ff),
      "transaction taken while the current row is not at the head")
   `BPD_ASSERT(a_shift_poke_excl, clock, reset, !(ring_ctrl.shift && ring_ctrl.poke),
      "ring shifted and updated in place together")
   `BPD_ASSERT_NEXT(a_pad_restart, clock, reset, req_fire && is_pad && row_wrap, col_ff == '0,
      "column count not restarted by final padding")
   `BPD_ASSERT_NEXT(a_excess_no_effect, clock, reset, req_fire && excess, $stable(row_ff),
      "dropped pixel advanced the row")

endmodule

`default_nettype wire

FILE: sim/alpha_boundary_pixel_detect_checker.sv
`timescale 1ns / 1ps
// Checker for the alpha boundary pixel detector: watches the request, result and register
// ports, predicts every reported boundary pixel and compares it with what the block sends.
// Depends on bpd_pkg; instantiated beside the block by alpha_boundary_pixel_detect_top_tb.

module alpha_boundary_pixel_detect_checker import bpd_pkg::*; #(
   parameter int MAX_SIDE = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [PIX_W-1:0]     req_pixel_word,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [EDGE_W-1:0]    rsp_edge_x,
   input  logic [EDGE_W-1:0]    rsp_edge_y,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   mismatch_count,
   output int                   outstanding_edges
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [EDGE_W-1:0] x;
      logic [EDGE_W-1:0] y;
   } boundary_pixel_type;

   logic [CFG_W-1:0]   width_reg;
   logic [CFG_W-1:0]   height_reg;
   bit                 newest_opaque [MAX_SIDE];
   bit                 older_opaque  [MAX_SIDE];
   int unsigned        column_idx;
   int unsigned        row_idx;
   boundary_pixel_type expected_boundaries [$];

   function automatic int unsigned clamped_side(input logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_SIDE) return MAX_SIDE;
      return value;
   endfunction

   // Advances the frame state by one accepted transaction and returns whether it
   // decides a boundary pixel one column back.
   function automatic bit predict_boundary(input logic [KIND_W-1:0] kind,
                                           input logic [PIX_W-1:0]  word,
                                           output boundary_pixel_type found);
      int unsigned w, h, x, y;
      bit          is_pad, opaque, hit;
      w      = clamped_side(width_reg);
      h      = clamped_side(height_reg);
      is_pad = (kind == KIND_PAD);
      opaque = !is_pad && (word[ALPHA_LSB +: ALPHA_W] == ALPHA_OPAQUE);
      y      = row_idx;
      hit    = 1'b0;
      found  = '0;
      // Pixels beyond the configured width are dropped without touching any state.
      if (!is_pad && column_idx >= w) return 1'b0;
      if (column_idx >= 1 && column_idx - 1 < w && y < h && y < MAX_SIDE) begin
         x = column_idx - 1;
         if (!newest_opaque[y]) begin
            hit = (x > 0 && older_opaque[y])
               || (!is_pad && x + 1 < w && opaque)
               || (y > 0 && older_opaque[y - 1])
               || (y + 1 < h && y + 1 < MAX_SIDE && newest_opaque[y + 1]);
            found.x = EDGE_W'(x);
            found.y = EDGE_W'(y);
         end
      end
      if (y < MAX_SIDE) begin
         older_opaque[y]  = newest_opaque[y];
         newest_opaque[y] = opaque;
      end
      row_idx = y + 1;
      if (row_idx >= h) begin
         row_idx    = 0;
         column_idx = is_pad ? 0 : column_idx + 1;
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin : monitor
      boundary_pixel_type want;
      boundary_pixel_type seen;
      if (reset) begin
         width_reg  = CFG_W'(SIDE_RESET);
         height_reg = CFG_W'(SIDE_RESET);
         for (int i = 0; i < MAX_SIDE; i++) begin
            newest_opaque[i] = 1'b0;
            older_opaque[i]  = 1'b0;
         end
         column_idx = 0;
         row_idx    = 0;
         expected_boundaries.delete();
         mismatch_count = 0;
         outstanding_edges <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_wdata;
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
         // A result always trails its request, so retire before predicting.
         if (rsp_valid && !rsp_stall) begin
            if (expected_boundaries.size() == 0) begin
               report_mismatch($sformatf("unexpected boundary pixel x=%0d y=%0d",
                                         rsp_edge_x, rsp_edge_y));
            end else begin
               want = expected_boundaries.pop_front();
               if (rsp_edge_x !== want.x)
                  report_mismatch($sformatf("edge_x: expected %0d, actual %0d",
                                            want.x, rsp_edge_x));
               if (rsp_edge_y !== want.y)
                  report_mismatch($sformatf("edge_y: expected %0d, actual %0d",
                                            want.y, rsp_edge_y));
            end
         end
         if (req_valid && !req_stall) begin
            if (predict_boundary(req_kind, req_pixel_word, seen))
               expected_boundaries.push_back(seen);
         end
         outstanding_edges <= expected_boundaries.size();
      end
   end

endmodule

FILE: sim/alpha_boundary_pixel_detect_top_tb.sv
`timescale 1ns / 1ps
// Top-level testbench of the alpha boundary pixel detector: drives pixel, padding and
// register transactions and gives the verdict. Depends on bpd_pkg, the block and
// alpha_boundary_pixel_detect_checker, which does all prediction and comparison.

module alpha_boundary_pixel_detect_top_tb import bpd_pkg::*;;

   localparam int MAX_SIDE     = 1024;
   localparam int RANDOM_ITEMS = 1200;
   // The block answers in the cycle after a transaction; spare cycles cover any
   // transaction that is still being worked on without producing a result.
   localparam int DRAIN_CYCLES = 8;
   // Length of the single long hold-off on the result side, in clock cycles.
   localparam int HOLD_CYCLES  = 600;

   // Size register values at and beyond the limits, including the clamped ones.
   localparam logic [CFG_W-1:0] EXTREME_SIDES [4] = '{11'd0, 11'd1, 11'd1024, 11'd2047};

   // A 3 by 3 frame, column by column: opaque, transparent and nearly opaque alphas.
   localparam logic [PIX_W-1:0] DIRECTED_PIXELS [9] = '{
      32'hFF00_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h00FF_FFFF, 32'hFEFF_FFFF, 32'hFF00_FF00,
      32'h7FFF_FFFF, 32'h0000_0000, 32'hFFAB_CDEF
   };

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind       = KIND_PIXEL;
   logic [PIX_W-1:0]     req_pixel_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [EDGE_W-1:0]    rsp_edge_x;
   logic [EDGE_W-1:0]    rsp_edge_y;
   logic                 csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0]     csr_wdata      = '0;

   int                   mismatch_count;
   int                   outstanding_edges;

   // Stimulus bookkeeping shared by the sender and the result side.
   bit                   quiet     = 1'b0;
   bit                   hold_go   = 1'b0;
   bit                   hold_done = 1'b0;
   int                   items_sent = 0;
   logic [CFG_W-1:0]     width_now;
   logic [CFG_W-1:0]     height_now;

   alpha_boundary_pixel_detect_top #(
      .MAX_SIDE(MAX_SIDE)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_pixel_word (req_pixel_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_edge_x     (rsp_edge_x),
      .rsp_edge_y     (rsp_edge_y),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   alpha_boundary_pixel_detect_checker #(
      .MAX_SIDE(MAX_SIDE)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_pixel_word    (req_pixel_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_x        (rsp_edge_x),
      .rsp_edge_y        (rsp_edge_y),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .outstanding_edges (outstanding_edges)
   );

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The size that the block actually works with once a register value is clamped.
   function automatic int unsigned usable_side(input logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_SIDE) return MAX_SIDE;
      return value;
   endfunction

   // Alpha is mostly fully opaque or fully transparent, so that boundaries are common,
   // with some arbitrary values in between; the colour bits are always random.
   function automatic logic [PIX_W-1:0] random_pixel();
      int unsigned      pick;
      logic [ALPHA_W-1:0] alpha;
      pick = $urandom_range(0, 99);
      if (pick < 45)      alpha = ALPHA_OPAQUE;
      else if (pick < 80) alpha = '0;
      else                alpha = ALPHA_W'($urandom_range(0, 255));
      return {alpha, (PIX_W - ALPHA_W)'($urandom)};
   endfunction

   // Offers one request transaction and returns at the clock edge that accepts it.
   // The payload stays put while the block stalls; gaps are only ever inserted before
   // valid is raised, so valid never follows the stall.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PIX_W-1:0] word);
      if (!quiet && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_pixel_word <= word;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Stops offering and waits until every predicted result has been taken, then lets
   // the block settle so that a register write finds it idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding_edges != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the width and/or the height register, one per clock.
   task automatic set_sizes(input bit write_w, input bit write_h,
                            input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      if (write_w) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_IMAGE_WIDTH;
         csr_wdata    <= w;
         @(posedge clock);
         width_now = w;
      end
      if (write_h) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_IMAGE_HEIGHT;
         csr_wdata    <= h;
         @(posedge clock);
         height_now = h;
      end
      csr_write_en <= 1'b0;
   endtask

   // One frame of w columns of h pixels followed by h padding transactions. Now and
   // then the frame is broken: surplus pixels after the last column, padding that
   // arrives before the width is complete (possibly with no columns at all), or a cut
   // in the middle of a column, which leaves the counters out of step.
   task automatic send_frame(input int unsigned w, input int unsigned h, output bit in_step);
      int unsigned pick, cols, extra;
      pick    = $urandom_range(0, 99);
      in_step = 1'b1;
      cols    = (pick >= 83) ? $urandom_range(0, w - 1) : w;
      repeat (cols * h) send_item(KIND_PIXEL, random_pixel());
      if (pick >= 96) begin
         repeat ($urandom_range(1, h)) send_item(KIND_PIXEL, random_pixel());
         repeat ($urandom_range(0, h)) send_item(KIND_PAD, $urandom);
         in_step = 1'b0;
      end else begin
         if (pick >= 75 && pick < 83) begin
            // Surplus pixels are ignored by the block and are not counted.
            extra = $urandom_range(1, 3);
            repeat (extra) send_item(KIND_PIXEL, random_pixel());
            items_sent -= extra;
         end
         repeat (h) send_item(KIND_PAD, $urandom);
      end
   endtask

   // Result side: stalls in about a fifth of the cycles, never during the quiet phase,
   // and once holds off for a long stretch so that the block fills and stalls its
   // requests while the sender keeps offering.
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
         end
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] new_w;
      logic [CFG_W-1:0] new_h;
      int unsigned      phase;
      int unsigned      extreme_idx;
      int unsigned      random_goal;
      int unsigned      frames;
      bit               aligned;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part on a 3 by 3 frame. The first column decides nothing; the second
      // and third are decided by the column after them and by the padding.
      set_sizes(1'b1, 1'b1, 11'd3, 11'd3);
      for (int i = 0; i < 9; i++) send_item(KIND_PIXEL, DIRECTED_PIXELS[i]);
      // A pixel once the width is complete is ignored.
      send_item(KIND_PIXEL, 32'hFFFF_FFFF);
      // Padding carries an opaque word that must not count as opaque.
      repeat (3) send_item(KIND_PAD, 32'hFFFF_FFFF);
      // Padding when no column has arrived only moves the row on.
      repeat (3) send_item(KIND_PAD, 32'h0000_0000);
      // Padding after one column of three decides that column early.
      send_item(KIND_PIXEL, 32'h0000_0000);
      send_item(KIND_PIXEL, 32'hFFFF_FFFF);
      send_item(KIND_PIXEL, 32'h00FF_FFFF);
      repeat (3) send_item(KIND_PAD, 32'h8000_0000);
      wait_drained();

      // Random part, in phases separated by idle points where the sizes may change.
      random_goal = items_sent + RANDOM_ITEMS;
      phase       = 0;
      extreme_idx = 0;
      aligned     = 1'b1;
      while (items_sent < random_goal) begin
         if (phase % 4 == 3) begin
            new_w = EXTREME_SIDES[extreme_idx % 4];
            new_h = EXTREME_SIDES[(extreme_idx + 2) % 4];
            extreme_idx++;
         end else if (phase == 2 || phase == 4) begin
            new_w = CFG_W'(8);
            new_h = CFG_W'(8);
         end else begin
            new_w = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 1))
                                                : CFG_W'($urandom_range(1, 8));
            new_h = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 1))
                                                : CFG_W'($urandom_range(1, 12));
         end

         // After a frame was left unfinished the counters are brought back to the
         // start of a frame: with a height of one, a single padding transaction wraps
         // the row and clears the column count. The width changes mid-frame here too.
         if (!aligned) begin
            set_sizes(1'b1, 1'b1, new_w, 11'd1);
            send_item(KIND_PAD, $urandom);
            wait_drained();
            aligned = 1'b1;
         end
         set_sizes(new_w != width_now, new_h != height_now, new_w, new_h);

         // One phase runs with no gaps on either side, another with the long hold-off.
         quiet = (phase == 2);
         if (phase == 4) hold_go = 1'b1;

         if (phase % 4 == 3) begin
            // Extreme sizes would make whole frames far too long, so only the start of
            // a frame is sent and the next phase changes the sizes in the middle of it.
            repeat ($urandom_range(20, 60)) begin
               if ($urandom_range(0, 99) < 85) send_item(KIND_PIXEL, random_pixel());
               else                            send_item(KIND_PAD, $urandom);
            end
            aligned = 1'b0;
         end else begin
            frames = (phase == 2 || phase == 4) ? 3 : $urandom_range(1, 3);
            repeat (frames) begin
               if (aligned) send_frame(usable_side(width_now), usable_side(height_now), aligned);
            end
         end

         // The sender pauses here until every expected result has come back.
         wait_drained();
         quiet = 1'b0;
         phase++;
      end

      wait_drained();
      if (mismatch_count == 0 && outstanding_edges == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // The whole run stays well inside the watchdog limit even with every size change
   // realigning the full ring; reaching that limit means the block has hung.
   initial begin : watchdog
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
